// ===== sv/dam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_pkg
// Shared opcodes, error codes and controller command types.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MemWordsDefault = 100;

  localparam logic [6:0] OP_READ  = 7'd10;
  localparam logic [6:0] OP_WRITE = 7'd11;
  localparam logic [6:0] OP_LOAD  = 7'd20;
  localparam logic [6:0] OP_STORE = 7'd21;
  localparam logic [6:0] OP_ADD   = 7'd30;
  localparam logic [6:0] OP_SUB   = 7'd31;
  localparam logic [6:0] OP_DIV   = 7'd32;
  localparam logic [6:0] OP_MUL   = 7'd33;
  localparam logic [6:0] OP_JMP   = 7'd40;
  localparam logic [6:0] OP_JNEG  = 7'd41;
  localparam logic [6:0] OP_JZERO = 7'd42;
  localparam logic [6:0] OP_HALT  = 7'd43;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_DIVZERO = 2'd1;
  localparam logic [1:0] ERR_PASTEND = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;        // capture the input value of an accepted item
    logic mem_load;    // write input word at input address
    logic fetch;       // read instruction word at pc
    logic decode;      // latch the word and its quotient by 100
    logic operand;     // operand address digits
    logic opcode;      // opcode digits
    logic exec;        // start the operation
    logic div_step;    // one restoring-divide iteration
    logic div_done;    // commit quotient or product
    logic finish;      // register the result item
  } dam_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic is_div;
    logic div_last;
  } dam_sts_t;

endpackage

// ===== sv/decimal_accumulator_machine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_unit
// Decimal accumulator machine: load words, step instructions.
// ----------------------------------------------------------------------------
// A divide step runs longer than other items, set by the one-bit-per-cycle
// restoring divider. The result sits in an output register; the next item
// is taken once it is free or being taken. Memory reads are one registered
// port, so fetch and operand read are separate cycles. Never-written words
// read as zero.
module decimal_accumulator_machine_unit #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [6:0]  address,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic signed [31:0] write_value,
  output logic signed [31:0] accumulator_out,
  output logic [6:0]  program_counter_out,
  output logic        halted,
  output logic [1:0]  error_code
);
  import dam_pkg::*;

  dam_cmd_t cmd;
  dam_sts_t sts;

  dam_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(command), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  dam_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_address(address), .in_value(value),
    .res_write_valid(write_valid), .res_write_value(write_value),
    .res_acc(accumulator_out), .res_pc(program_counter_out),
    .res_halted(halted), .res_err(error_code)
  );

  // no new item while a finished result is still being held
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("item accepted while result blocked");

  // a halt never clears without reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && halted && !out_stall) |=> (!out_valid || halted))
    else $error("halt flag cleared");

  // error code only reported with halt
  a_err_halt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> halted)
    else $error("error without halt");
endmodule

// ===== sv/dam_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_datapath
// Memory, accumulator, counter, digit decode, multiplier and serial divider.
// ----------------------------------------------------------------------------
module dam_datapath #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dam_pkg::dam_cmd_t    cmd,
  output dam_pkg::dam_sts_t    sts,
  input  logic [6:0]           in_address,
  input  logic [31:0]          in_value,
  output logic                 res_write_valid,
  output logic [31:0]          res_write_value,
  output logic [31:0]          res_acc,
  output logic [6:0]           res_pc,
  output logic                 res_halted,
  output logic [1:0]           res_err
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [6:0] Last = 7'(MEM_WORDS - 1);
  // ceil(2^37 / 100): (x * Recip100) >> 37 is x / 100 for any 32-bit x
  localparam logic [31:0] Recip100 = 32'd1374389535;

  logic [31:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid;
  logic [31:0] rdata;

  logic [31:0] acc;
  logic [6:0]  pc;
  logic        halt_flag;
  logic [1:0]  err;
  logic [31:0] word;
  logic [6:0]  op;
  logic [6:0]  addr;
  logic        wvalid;
  logic [31:0] wval;
  logic [31:0] val_q;

  logic [31:0] prod;
  logic [31:0] rem, quo, dvs;
  logic [4:0]  div_cnt;
  logic        neg_q;

  // memory read address follows the phase
  logic [6:0] raddr;
  assign raddr = cmd.fetch ? pc : addr;

  // write port: loads, read instruction, store instruction
  logic        we;
  logic [6:0]  waddr;
  logic [31:0] wdata;
  always_comb begin
    we = 1'b0;
    waddr = in_address;
    wdata = in_value;
    if (cmd.mem_load) begin
      we = 1'b1;
    end else if (cmd.exec && op == OP_READ) begin
      we = 1'b1;
      waddr = addr;
      wdata = val_q;
    end else if (cmd.exec && op == OP_STORE) begin
      we = 1'b1;
      waddr = addr;
      wdata = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr < 7'(MEM_WORDS)) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rdata <= (raddr < 7'(MEM_WORDS)) ? mem[raddr[AW-1:0]] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we && waddr < 7'(MEM_WORDS)) begin
      valid[waddr[AW-1:0]] <= 1'b1;
    end
  end

  // operand or instruction word, zero when never written
  logic [31:0] mword;
  logic        rvalid;
  logic [6:0]  raddr_q;
  always_ff @(posedge clk) raddr_q <= raddr;
  assign rvalid = (raddr_q < 7'(MEM_WORDS)) && valid[raddr_q[AW-1:0]];
  assign mword = rvalid ? rdata : 32'd0;

  // split the word into digit pairs by reciprocal multiply, across the decode, operand and opcode steps
  logic [31:0] q100, q10000;
  logic [63:0] q100_prod, q10000_prod;
  assign q100_prod   = 64'(mword) * 64'(Recip100);
  assign q10000_prod = 64'(q100) * 64'(Recip100);
  logic [31:0] op_w, ad_w;
  assign op_w = q100 - q10000 * 32'd100;
  assign ad_w = word - q100 * 32'd100;

  function automatic logic [6:0] nxt_ok(input logic [6:0] p);
    return p + 7'd1;
  endfunction

  logic [31:0] dvd_abs, dvs_abs;
  assign dvd_abs = acc[31] ? -acc : acc;
  assign dvs_abs = mword[31] ? -mword : mword;

  logic [32:0] trial;
  assign trial = {1'b0, rem[30:0], quo[31]} - {1'b0, dvs};

  // hold the input value of the item in progress
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      val_q <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pc <= '0;
      halt_flag <= 1'b0;
      err <= ERR_NONE;
      wvalid <= 1'b0;
      wval <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.fetch) begin
        if (pc >= 7'(MEM_WORDS)) begin
          halt_flag <= 1'b1;
          err <= ERR_PASTEND;
        end
      end
      if (cmd.decode) begin
        word <= mword;
        q100 <= {5'd0, q100_prod[63:37]};
      end
      if (cmd.operand) begin
        addr <= word[31] ? 7'd0 : ad_w[6:0];
        q10000 <= {5'd0, q10000_prod[63:37]};
      end
      if (cmd.opcode) begin
        op <= word[31] ? 7'd0 : op_w[6:0];
      end
      if (cmd.exec) begin
        prod <= acc * mword;
        case (op)
          OP_WRITE: begin
            wvalid <= 1'b1;
            wval <= mword;
          end
          OP_LOAD: acc <= mword;
          OP_ADD: acc <= acc + mword;
          OP_SUB: acc <= acc - mword;
          OP_DIV: begin
            rem <= '0;
            quo <= dvd_abs;
            dvs <= dvs_abs;
            neg_q <= acc[31] ^ mword[31];
            div_cnt <= '0;
          end
          default: ;
        endcase
        // counter update; divide advances on completion
        case (op)
          OP_DIV: begin
            if (mword == 32'd0) begin
              halt_flag <= 1'b1;
              err <= ERR_DIVZERO;
            end
          end
          OP_HALT: halt_flag <= 1'b1;
          OP_JMP, OP_JNEG, OP_JZERO: begin
            if (op == OP_JMP || (op == OP_JNEG && acc[31]) ||
                (op == OP_JZERO && acc == 32'd0)) begin
              if (addr >= 7'(MEM_WORDS)) begin
                halt_flag <= 1'b1;
                err <= ERR_PASTEND;
              end else begin
                pc <= addr;
              end
            end else if (pc >= Last) begin
              halt_flag <= 1'b1;
              err <= ERR_PASTEND;
            end else begin
              pc <= nxt_ok(pc);
            end
          end
          default: begin
            if (pc >= Last) begin
              halt_flag <= 1'b1;
              err <= ERR_PASTEND;
            end else begin
              pc <= nxt_ok(pc);
            end
          end
        endcase
      end
      if (cmd.div_step) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      // commit the quotient and advance, or commit the product
      if (cmd.div_done) begin
        if (op == OP_DIV && !halt_flag) begin
          acc <= neg_q ? -quo : quo;
          if (pc >= Last) begin
            halt_flag <= 1'b1;
            err <= ERR_PASTEND;
          end else begin
            pc <= nxt_ok(pc);
          end
        end else if (op == OP_MUL) begin
          acc <= prod;
        end
      end
      // drop the write flag once the result is registered
      if (cmd.finish) begin
        wvalid <= 1'b0;
        wval <= '0;
      end
    end
  end

  assign sts.halted   = halt_flag;
  assign sts.is_div   = (op == OP_DIV) && !halt_flag;
  assign sts.div_last = (div_cnt == 5'd31);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_write_valid <= wvalid;
      res_write_value <= wval;
      res_acc <= acc;
      res_pc <= pc;
      res_halted <= halt_flag;
      res_err <= err;
    end
  end
endmodule

// ===== sv/dam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer: accepts an item, steps the datapath, hands over the result.
// ----------------------------------------------------------------------------
module dam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  output logic              out_valid,
  input  logic              out_stall,
  output dam_pkg::dam_cmd_t cmd,
  input  dam_pkg::dam_sts_t sts
);
  import dam_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_DEC  = 9'b000000100,
    S_OPND = 9'b000001000,
    S_RDOP = 9'b000010000,
    S_EXEC = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic out_full;
  logic fin;

  assign in_stall = (state != S_IDLE) || (out_full && out_stall);
  logic acc_in;
  assign acc_in = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_in) begin
          state_next = (in_command && !sts.halted) ? S_FETCH : S_FIN;
        end
      end
      S_FETCH: state_next = S_DEC;
      S_DEC:   state_next = sts.halted ? S_FIN : S_OPND;
      S_OPND:  state_next = S_RDOP;
      S_RDOP:  state_next = S_EXEC;
      S_EXEC:  state_next = S_DIV;
      S_DIV:   state_next = (!sts.is_div || sts.div_last) ? S_DONE : S_DIV;
      S_DONE:  state_next = S_FIN;
      S_FIN:   state_next = (out_full && out_stall) ? S_FIN : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.take     = acc_in;
    cmd.mem_load = acc_in && !in_command;
    cmd.fetch    = (state == S_FETCH);
    cmd.decode   = (state == S_DEC) && !sts.halted;
    cmd.operand  = (state == S_OPND);
    cmd.opcode   = (state == S_RDOP);
    cmd.exec     = (state == S_EXEC);
    cmd.div_step = (state == S_DIV) && sts.is_div;
    cmd.div_done = (state == S_DONE);
    fin = (state == S_FIN) && !(out_full && out_stall);
    cmd.finish   = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (fin) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  assign out_valid = out_full;
endmodule

// ===== dv/decimal_accumulator_machine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_unit_tb
// Drives load and step items into the accumulator machine, predicts each
// result from a local copy of memory, accumulator, counter and halt state,
// and checks every result item in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_unit_tb;
  import dam_pkg::*;

  localparam int NWORDS = MemWordsDefault;
  localparam int TOTAL_ITEMS = 1150;

  typedef struct packed {
    logic        wv;
    logic [31:0] wval;
    logic [31:0] acc;
    logic [6:0]  pc;
    logic        hlt;
    logic [1:0]  err;
  } machine_result_t;

  // compares results against the expected queue
  class result_scoreboard;
    machine_result_t pending[$];
    int errors = 0;

    function void note(machine_result_t r);
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(machine_result_t got);
      machine_result_t w;
      if (pending.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        w = pending.pop_front();
        if (got.wv !== w.wv) report("write_valid", got.wv, w.wv);
        if (got.wval !== w.wval) report("write_value", got.wval, w.wval);
        if (got.acc !== w.acc) report("accumulator_out", got.acc, w.acc);
        if (got.pc !== w.pc) report("program_counter_out", got.pc, w.pc);
        if (got.hlt !== w.hlt) report("halted", got.hlt, w.hlt);
        if (got.err !== w.err) report("error_code", got.err, w.err);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [6:0] address = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic write_valid;
  logic signed [31:0] write_value;
  logic signed [31:0] accumulator_out;
  logic [6:0] program_counter_out;
  logic halted;
  logic [1:0] error_code;

  decimal_accumulator_machine_unit dut (.*);

  result_scoreboard sb = new();

  // predicted machine state
  logic [31:0] m_mem[NWORDS];
  logic [31:0] m_acc;
  logic [6:0]  m_pc;
  logic        m_halt;
  logic [1:0]  m_err;

  bit quiet = 1'b0;
  int sent = 0;
  int o_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void stop_machine(logic [1:0] e);
    m_halt = 1'b1;
    m_err = e;
  endfunction

  function automatic void next_pc();
    if (m_pc + 1 >= NWORDS) stop_machine(ERR_PASTEND);
    else m_pc = m_pc + 7'd1;
  endfunction

  function automatic void branch_to(logic [6:0] t);
    if (t >= NWORDS) stop_machine(ERR_PASTEND);
    else m_pc = t;
  endfunction

  // advance the predicted machine by one item
  function automatic machine_result_t machine_step(logic cmd, logic [6:0] adr,
                                                   logic [31:0] val);
    machine_result_t r;
    logic [31:0] word, m;
    logic [6:0] op, opa;
    longint q;
    r = '0;
    if (cmd == 1'b0) begin
      if (adr < NWORDS) m_mem[adr] = val;
    end else if (!m_halt) begin
      if (m_pc >= NWORDS) begin
        stop_machine(ERR_PASTEND);
      end else begin
        word = m_mem[m_pc];
        op = '0;
        opa = '0;
        if (!word[31]) begin
          op = 7'((word / 100) % 100);
          opa = 7'(word % 100);
        end
        m = (opa < NWORDS) ? m_mem[opa] : 32'd0;
        case (op)
          OP_READ: begin
            if (opa < NWORDS) m_mem[opa] = val;
            next_pc();
          end
          OP_WRITE: begin
            r.wv = 1'b1;
            r.wval = m;
            next_pc();
          end
          OP_LOAD: begin
            m_acc = m;
            next_pc();
          end
          OP_STORE: begin
            if (opa < NWORDS) m_mem[opa] = m_acc;
            next_pc();
          end
          OP_ADD: begin
            m_acc = m_acc + m;
            next_pc();
          end
          OP_SUB: begin
            m_acc = m_acc - m;
            next_pc();
          end
          OP_DIV: begin
            if (m == 0) begin
              stop_machine(ERR_DIVZERO);
            end else begin
              q = longint'($signed(m_acc)) / longint'($signed(m));
              m_acc = q[31:0];
              next_pc();
            end
          end
          OP_MUL: begin
            m_acc = m_acc * m;
            next_pc();
          end
          OP_JMP: branch_to(opa);
          OP_JNEG: begin
            if (m_acc[31]) branch_to(opa);
            else next_pc();
          end
          OP_JZERO: begin
            if (m_acc == 0) branch_to(opa);
            else next_pc();
          end
          OP_HALT: stop_machine(ERR_NONE);
          default: next_pc();
        endcase
      end
    end
    r.acc = m_acc;
    r.pc = m_pc;
    r.hlt = m_halt;
    r.err = m_err;
    return r;
  endfunction

  // true when the next step item would stop the machine
  function automatic bit step_would_halt();
    logic [31:0] saved[NWORDS];
    logic [31:0] a;
    logic [6:0] p;
    logic h;
    logic [1:0] e;
    machine_result_t r;
    bit res;
    saved = m_mem;
    a = m_acc;
    p = m_pc;
    h = m_halt;
    e = m_err;
    r = machine_step(1'b1, 7'd0, 32'd0);
    res = m_halt;
    m_mem = saved;
    m_acc = a;
    m_pc = p;
    m_halt = h;
    m_err = e;
    return res;
  endfunction

  // present one item, hold until accepted, then predict it
  task automatic send_item(logic cmd, logic [6:0] adr, logic [31:0] val);
    in_valid <= 1'b1;
    command <= cmd;
    address <= adr;
    value <= val;
    do @(posedge clk); while (in_stall);
    sb.note(machine_step(cmd, adr, val));
    sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_word(int adr, logic [31:0] val);
    send_item(1'b0, 7'(adr), val);
  endtask

  task automatic step_once(logic [31:0] val);
    send_item(1'b1, 7'd0, val);
  endtask

  function automatic logic [31:0] random_instr();
    logic [6:0] ops[10];
    int k;
    ops = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV, OP_MUL,
            OP_JNEG, OP_JZERO};
    k = $urandom_range(0, 19);
    if (k == 0) return $urandom();
    if (k == 1) return 32'($urandom_range(0, 9999));
    if (k == 2) return 32'(OP_JMP) * 100 + $urandom_range(0, 99);
    return $urandom_range(0, 20) * 10000 + 32'(ops[$urandom_range(0, 9)]) * 100
           + $urandom_range(0, 99);
  endfunction

  function automatic logic [31:0] random_data();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'd0;
      4: return 32'($urandom_range(0, 20));
      default: return $urandom();
    endcase
  endfunction

  // collect result items
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{write_valid, write_value, accumulator_out, program_counter_out,
                 halted, error_code});
  end

  // stall the result side in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      o_left = 0;
    end else if (o_left > 0) begin
      o_left--;
      if (o_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      o_left = $urandom_range(1, 6);
    end
  end

  initial begin
    logic [31:0] prog[16];
    int b, k, z;
    foreach (m_mem[i]) m_mem[i] = '0;
    m_acc = '0;
    m_pc = '0;
    m_halt = 1'b0;
    m_err = ERR_NONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, wrap, divide overflow, negative and unknown words
    load_word(50, 32'h7fffffff);
    load_word(51, 32'h80000000);
    load_word(52, 32'hffffffff);
    load_word(127, 32'h12345678);
    prog = '{2050, 3051, 4105, 0, 0, 3352, 4209, 3152, 2051, 3252, 1054, 1154,
             2155, 32'h80001154, 9999, 4215};
    foreach (prog[i]) load_word(i, prog[i]);
    repeat (15) step_once(32'hdeadbeef);

    // random: program fragments, data loads, guarded steps
    while (sent < TOTAL_ITEMS) begin
      if (sent > TOTAL_ITEMS - 150) quiet = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 15) begin
        load_word($urandom_range(0, 127), random_data());
      end else if (k < 25) begin
        b = $urandom_range(0, 90);
        for (int i = 0; i < $urandom_range(1, 6); i++) load_word(b + i, random_instr());
        load_word(m_pc, 32'(OP_JMP) * 100 + b);
      end else if (step_would_halt()) begin
        load_word(m_pc, 32'(OP_JMP) * 100 + $urandom_range(0, 98));
      end else begin
        step_once($urandom());
      end
    end

    // stop the machine one of three ways, then poke it while halted
    case ($urandom_range(0, 2))
      0: begin
        load_word(m_pc, 32'(OP_HALT) * 100);
        step_once(0);
      end
      1: begin
        z = (m_pc == 98) ? 97 : 98;
        load_word(z, 0);
        load_word(m_pc, 32'(OP_DIV) * 100 + z);
        step_once(0);
      end
      default: begin
        if (m_pc != 99) load_word(m_pc, 32'(OP_JMP) * 100 + 99);
        load_word(99, 0);
        step_once(0);
        if (!m_halt) step_once(0);
      end
    endcase
    step_once($urandom());
    load_word(5, $urandom());
    step_once($urandom());
    in_valid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dam_pkg.sv
sv/dam_datapath.sv
sv/dam_ctrl.sv
sv/decimal_accumulator_machine_unit.sv
dv/decimal_accumulator_machine_unit_tb.sv
